@@ hw/rtl/cs_pkg.sv @@
package cs_pkg;

  typedef enum logic [1:0] {
    OP_COS        = 2'd0,
    OP_SIN        = 2'd1,
    OP_SIN_NOFOLD = 2'd2,
    OP_RAW        = 2'd3
  } op_e;

  localparam int unsigned NumRot = 6;

  // Angle landmarks, 4096 units per turn.
  localparam logic signed [16:0] AngQuarter   = 17'sh00400;
  localparam logic signed [16:0] AngHalf      = 17'sh00800;
  localparam logic signed [16:0] AngThreeQtr  = 17'sh00C00;
  localparam logic signed [16:0] AngHalfMin1  = 17'sh007FF;
  localparam logic signed [16:0] AngFullMin1  = 17'sh00FFF;

  // Gain-compensated start vector.
  localparam logic signed [15:0] XInit = 16'sh09B7;

  localparam logic signed [16:0] AtanTab [NumRot] = '{
    17'sh001FF, 17'sh0012E, 17'sh0009F, 17'sh00051, 17'sh00029, 17'sh00014
  };

  typedef struct packed {
    logic sel_cos;  // take the core cosine as primary value
    logic negate;   // negate the primary value
    logic raw;      // also return the core cosine as secondary value
  } ctrl_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] z;
    ctrl_t              ctrl;
  } rot_t;

endpackage

@@ hw/rtl/cs_fold.sv @@
module cs_fold
  import cs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] angle_i,
  input  logic [1:0]         opcode_i,
  output logic               valid_o,
  output rot_t               rot_o
);

  logic               valid_q;
  rot_t               rot_q;
  rot_t               rot_d;
  logic signed [16:0] ang;
  logic signed [16:0] absv;
  logic signed [16:0] a;
  logic               neg;
  op_e                op;

  always_comb begin
    ang  = 17'(angle_i);
    neg  = angle_i[15];
    absv = neg ? -ang : ang;
    a    = {5'd0, absv[11:0]};
    op   = op_e'(opcode_i);

    rot_d.x    = XInit;
    rot_d.y    = '0;
    rot_d.z    = a;
    rot_d.ctrl = '0;

    unique case (op)
      OP_COS: begin
        rot_d.ctrl.sel_cos = 1'b1;
        priority if (a < AngQuarter) begin
          rot_d.z = a;
        end else if (a < AngHalf) begin
          rot_d.z = AngHalfMin1 - a;
          rot_d.ctrl.negate = 1'b1;
        end else if (a < AngThreeQtr) begin
          rot_d.z = a - AngHalf;
          rot_d.ctrl.negate = 1'b1;
        end else begin
          rot_d.z = AngFullMin1 - a;
        end
      end
      OP_SIN: begin
        priority if (a < AngQuarter) begin
          rot_d.z = a;
          rot_d.ctrl.negate = neg;
        end else if (a < AngHalf) begin
          rot_d.z = AngHalfMin1 - a;
          rot_d.ctrl.negate = neg;
        end else if (a < AngThreeQtr) begin
          rot_d.z = a - AngHalf;
          rot_d.ctrl.negate = ~neg;
        end else begin
          rot_d.z = AngFullMin1 - a;
          rot_d.ctrl.negate = ~neg;
        end
      end
      OP_SIN_NOFOLD: begin
        priority if (ang < AngQuarter) begin
          rot_d.z = ang;
        end else if (ang < AngHalf) begin
          rot_d.z = AngHalfMin1 - ang;
        end else if (ang < AngThreeQtr) begin
          rot_d.z = ang - AngHalf;
          rot_d.ctrl.negate = 1'b1;
        end else begin
          rot_d.z = AngFullMin1 - ang;
          rot_d.ctrl.negate = 1'b1;
        end
      end
      OP_RAW: begin
        rot_d.z = ang;
        rot_d.ctrl.raw = 1'b1;
      end
      default: begin
        rot_d.z = ang;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

@@ hw/rtl/cs_cell.sv @@
module cs_cell
  import cs_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  rot_t rot_i,
  output logic valid_o,
  output rot_t rot_o
);

  logic               valid_q;
  rot_t               rot_q;
  rot_t               rot_d;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic signed [16:0] z_in;
  logic signed [15:0] dx;
  logic signed [15:0] dy;

  // One micro-rotation: direction from the sign of the residual angle.
  always_comb begin
    x_in = rot_i.x;
    y_in = rot_i.y;
    z_in = rot_i.z;
    dx   = y_in >>> Idx;
    dy   = x_in >>> Idx;
    rot_d.ctrl = rot_i.ctrl;
    if (!z_in[16]) begin
      rot_d.x = x_in - dx;
      rot_d.y = y_in + dy;
      rot_d.z = z_in - AtanTab[Idx];
    end else begin
      rot_d.x = x_in + dx;
      rot_d.y = y_in - dy;
      rot_d.z = z_in + AtanTab[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

@@ hw/rtl/cs_corr.sv @@
module cs_corr
  import cs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         en_i,
  input  logic               valid_i,
  input  rot_t               rot_i,
  output logic [1:0]         valid_o,
  output logic signed [18:0] primary_o,
  output logic signed [18:0] secondary_o
);

  logic [1:0]         valid_q;
  logic signed [32:0] p_zy_q;
  logic signed [32:0] p_zx_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  ctrl_t              ctrl_q;
  logic signed [16:0] z_in;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic signed [21:0] cs_w;
  logic signed [21:0] sn_w;
  logic signed [18:0] sel;
  logic signed [18:0] prim_d;
  logic signed [18:0] sec_d;
  logic signed [18:0] prim_q;
  logic signed [18:0] sec_q;

  assign z_in = rot_i.z;
  assign x_in = rot_i.x;
  assign y_in = rot_i.y;

  // Linear correction by the residual angle.
  always_comb begin
    cs_w   = 22'(x_q) - 22'(p_zy_q >>> 12);
    sn_w   = 22'(y_q) + 22'(p_zx_q >>> 12);
    sel    = ctrl_q.sel_cos ? cs_w[18:0] : sn_w[18:0];
    prim_d = ctrl_q.negate ? -sel : sel;
    sec_d  = ctrl_q.raw ? cs_w[18:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) begin
        valid_q[0] <= valid_i;
      end
      if (en_i[1]) begin
        valid_q[1] <= valid_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0] && valid_i) begin
      p_zy_q <= 33'(z_in) * 33'(y_in);
      p_zx_q <= 33'(z_in) * 33'(x_in);
      x_q    <= x_in;
      y_q    <= y_in;
      ctrl_q <= rot_i.ctrl;
    end
    if (en_i[1] && valid_q[0]) begin
      prim_q <= prim_d;
      sec_q  <= sec_d;
    end
  end

  assign valid_o     = valid_q;
  assign primary_o   = prim_q;
  assign secondary_o = sec_q;

endmodule

@@ hw/rtl/cordic_sine_cosine_top.sv @@
// Channel  Direction  Handshake                Word
// in       sink       in_valid_i / in_stall_o  angle_i[15:0] s, opcode_i[1:0]
// out      source     out_valid_o / out_stall_i primary_value_o[18:0] s,
//                                               secondary_value_o[18:0] s
//
// One word in, one word out. The pipeline has one angle-fold stage, six
// rotation cells, one multiply stage and one correction/output stage.
// Throughput is one word per cycle while out_stall_i is low (fully unrolled chain).
// Reset (rst_ni low, asynchronous) empties every stage; no warm-up is needed.
// Every stage advances while the stage after it is empty or advancing, so
// bubbles close up under out_stall_i; in_stall_o rises only when all nine
// stages hold a word and the output is stalled.
module cordic_sine_cosine_top
  import cs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] angle_i,
  input  logic [1:0]         opcode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [18:0] primary_value_o,
  output logic signed [18:0] secondary_value_o
);

  localparam int unsigned NumStg = NumRot + 3;

  logic [NumStg-1:0] vld;
  logic [NumStg-1:0] en;
  rot_t              rot [NumRot+1];

  // Advance chain: a stage moves on when it is empty or its successor moves.
  always_comb begin
    en[NumStg-1] = ~vld[NumStg-1] | ~out_stall_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign in_stall_o = ~en[0];

  // Fold the angle into the core's quadrant (not for OP_RAW) and note the output sign.
  cs_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en[0]),
    .valid_i  (in_valid_i),
    .angle_i  (angle_i),
    .opcode_i (opcode_i),
    .valid_o  (vld[0]),
    .rot_o    (rot[0])
  );

  // Chain of rotation cells, one shift amount each.
  for (genvar g = 0; g < NumRot; g++) begin : g_cell
    cs_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g+1]),
      .valid_i (vld[g]),
      .rot_i   (rot[g]),
      .valid_o (vld[g+1]),
      .rot_o   (rot[g+1])
    );
  end

  // Residual-angle correction, result select and output register.
  cs_corr u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en[NumStg-1:NumStg-2]),
    .valid_i     (vld[NumRot]),
    .rot_i       (rot[NumRot]),
    .valid_o     (vld[NumStg-1:NumStg-2]),
    .primary_o   (primary_value_o),
    .secondary_o (secondary_value_o)
  );

  assign out_valid_o = vld[NumStg-1];

  // Hold off the source only when the sink is stalling.
  a_stall_from_sink : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && out_valid_o))
    else $error("input stalled while output drains");

  // An accepted word lands in the fold stage.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld[0])
    else $error("accepted word lost at fold stage");

  // An empty output stage never stalls the chain behind it.
  a_no_stall_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> en[NumStg-1] && !in_stall_o)
    else $error("chain stalled with empty output stage");

endmodule

@@ tb/cordic_sine_cosine_checker.sv @@
`timescale 1ns / 100ps

module cordic_sine_cosine_checker
  import cs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] angle_i,
  input  logic [1:0]         opcode_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [18:0] primary_value_i,
  input  logic signed [18:0] secondary_value_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  localparam longint GainStart = 'h9B7;
  localparam longint Quarter   = 'h400;
  localparam longint Half      = 'h800;
  localparam longint ThreeQtr  = 'hC00;
  localparam longint HalfMin1  = 'h7FF;
  localparam longint FullMin1  = 'hFFF;
  localparam longint TurnMask  = 'hFFF;

  typedef struct {
    logic signed [15:0] angle;
    op_e                op;
    logic signed [18:0] primary;
    logic signed [18:0] secondary;
  } trig_word_t;

  trig_word_t expected_trig[$];
  trig_word_t oldest;
  int         mismatches = 0;
  int         in_flight  = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = in_flight;

  function automatic longint atan_step(input int i);
    case (i)
      0:       return 'h1FF;
      1:       return 'h12E;
      2:       return 'h9F;
      3:       return 'h51;
      4:       return 'h29;
      default: return 'h14;
    endcase
  endfunction

  // Six rotations, then a linear correction by the leftover angle.
  function automatic void cordic_rotate(input longint start, output longint sn,
                                        output longint cs);
    longint x, y, z, dx, dy;
    x = GainStart;
    y = 0;
    z = start;
    for (int i = 0; i < 6; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end
    end
    cs = x - ((z * y) >>> 12);
    sn = y + ((z * x) >>> 12);
  endfunction

  function automatic trig_word_t predict_trig(input logic signed [15:0] ang_in,
                                              input op_e op);
    longint     ang, a, sn, cs, prim, sec;
    bit         neg;
    trig_word_t w;
    ang  = ang_in;
    neg  = ang < 0;
    a    = (neg ? -ang : ang) & TurnMask;
    prim = 0;
    sec  = 0;
    case (op)
      OP_COS: begin
        if (a < Quarter) begin
          cordic_rotate(a, sn, cs);
          prim = cs;
        end else if (a < ThreeQtr) begin
          cordic_rotate(a < Half ? HalfMin1 - a : a - Half, sn, cs);
          prim = -cs;
        end else begin
          cordic_rotate(FullMin1 - a, sn, cs);
          prim = cs;
        end
      end
      OP_SIN: begin
        if (a < Quarter) begin
          cordic_rotate(a, sn, cs);
        end else if (a < Half) begin
          cordic_rotate(HalfMin1 - a, sn, cs);
        end else begin
          cordic_rotate(a < ThreeQtr ? a - Half : FullMin1 - a, sn, cs);
          sn = -sn;
        end
        prim = neg ? -sn : sn;
      end
      OP_SIN_NOFOLD: begin
        if (ang < Quarter) begin
          cordic_rotate(ang, sn, cs);
          prim = sn;
        end else if (ang < Half) begin
          cordic_rotate(HalfMin1 - ang, sn, cs);
          prim = sn;
        end else begin
          cordic_rotate(ang < ThreeQtr ? ang - Half : FullMin1 - ang, sn, cs);
          prim = -sn;
        end
      end
      default: begin
        cordic_rotate(ang, sn, cs);
        prim = sn;
        sec  = cs;
      end
    endcase
    w.angle     = ang_in;
    w.op        = op;
    w.primary   = prim[18:0];
    w.secondary = sec[18:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input trig_word_t want,
                                 input logic signed [18:0] got,
                                 input logic signed [18:0] exp_val);
    mismatches++;
    $display("%0t: %s mismatch, angle %0d op %s: got %0d, expected %0d",
             $realtime, what, want.angle, want.op.name(), got, exp_val);
  endtask

  // Check the output side before queueing the new word: an accepted word is registered before it can reach the output.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_trig.delete();
      in_flight = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_trig.size() == 0) begin
          oldest.angle = '0;
          oldest.op    = OP_RAW;
          report_mismatch("unexpected word", oldest, primary_value_i, '0);
        end else begin
          oldest = expected_trig.pop_front();
          if (primary_value_i !== oldest.primary)
            report_mismatch("primary", oldest, primary_value_i, oldest.primary);
          if (secondary_value_i !== oldest.secondary)
            report_mismatch("secondary", oldest, secondary_value_i, oldest.secondary);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_trig.push_back(predict_trig(angle_i, op_e'(opcode_i)));
      in_flight = expected_trig.size();
    end
  end

endmodule

@@ tb/cordic_sine_cosine_top_tb.sv @@
`timescale 1ns / 100ps

module cordic_sine_cosine_top_tb;
  import cs_pkg::*;

  localparam int NumBlocks     = 11;
  localparam int WordsPerBlock = 100;
  // Long enough for nine stages to fill and push back on the input.
  localparam int HoldOffCycles = 80;
  // Pipeline is nine deep; leave margin for stray words after the last one.
  localparam int DrainCycles   = 30;
  // Sized for roughly 1100 words behind long gaps and stalls, with a wide margin.
  localparam int LimitNs       = 6_000_000;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [15:0] angle     = '0;
  logic [1:0]         opcode    = OP_COS;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [18:0] primary_value;
  logic signed [18:0] secondary_value;

  int mismatches;
  int pending;

  // Handshake flags between the sender and the receiver process.
  bit hold_off_req = 1'b0;
  bit stall_on     = 1'b0;

  // Quadrant edges plus both ends of the 16-bit range.
  logic signed [15:0] corner_angles [6] = '{
    16'sh0000, 16'sh03FF, 16'sh0800, 16'sh0C00, 16'sh7FFF, -16'sh8000
  };

  cordic_sine_cosine_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .angle_i           (angle),
    .opcode_i          (opcode),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .primary_value_o   (primary_value),
    .secondary_value_o (secondary_value)
  );

  cordic_sine_cosine_checker trig_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .angle_i           (angle),
    .opcode_i          (opcode),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .primary_value_i   (primary_value),
    .secondary_value_i (secondary_value),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly no gap or a short one; now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias toward quadrant edges and the folded range, keep plenty of full-range
  // values so every angle bit toggles.
  function automatic logic signed [15:0] pick_angle();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom_range(0, 16'hFFFF);
    end else if (r < 7) begin
      v = $urandom_range(0, 'hFFF);
    end else if (r < 9) begin
      v = (int'($urandom_range(0, 15)) - 8) * 'h400 + int'($urandom_range(0, 2)) - 1;
    end else begin
      v = -int'($urandom_range(0, 'hFFF));
    end
    return v[15:0];
  endfunction

  // Offer one word after an optional idle gap and hold it until accepted.
  // Drop valid only when a gap follows, so valid never toggles within a step.
  task automatic drive_word(input logic signed [15:0] ang, input op_e op,
                            input int idle);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle    <= ang;
    opcode   <= op;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat (pick_idle() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Sender: directed corners, then random blocks with varying pressure.
  initial begin
    bit gaps_on;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sweep every opcode across the corner angles back to back.
    foreach (corner_angles[i]) begin
      for (int op = 0; op < 4; op++) drive_word(corner_angles[i], op_e'(op), 0);
    end
    // Negative sine angle exercises the sign restore.
    drive_word(-16'sh0001, OP_SIN, 0);
    wait_drained();

    for (int blk = 0; blk < NumBlocks; blk++) begin
      // Hold-off blocks send back to back so the pipeline backs up.
      gaps_on  = (blk % 3 != 0) && (blk != 2) && (blk != 7);
      stall_on = $urandom_range(0, 3) != 0;
      if (blk == 2 || blk == 7) hold_off_req = 1'b1;
      for (int k = 0; k < WordsPerBlock; k++) begin
        drive_word(pick_angle(), op_e'($urandom_range(0, 3)), gaps_on ? pick_idle() : 0);
      end
      // Pause the sender until the pipeline runs empty.
      if (blk == 4 || blk == 9) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: end the run as failed once LimitNs has passed.
  initial begin
    #(LimitNs);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ cordic_sine_cosine_top.f @@
hw/rtl/cs_pkg.sv
hw/rtl/cs_fold.sv
hw/rtl/cs_cell.sv
hw/rtl/cs_corr.sv
hw/rtl/cordic_sine_cosine_top.sv
tb/cordic_sine_cosine_checker.sv
tb/cordic_sine_cosine_top_tb.sv
